/* rtl/core/cpso_pkg.sv */
// Package for the Chase-Pyndiah soft-output block: shared codes and constants.
// No dependencies.
`default_nettype none
package cpso_pkg;
  localparam int unsigned MetricInvalid = 16383;

  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_VECTOR = 2'd1,
    FUNC_LRP    = 2'd2,
    FUNC_START  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    REG_COEF_CHANNEL    = 3'd0,
    REG_COEF_COMPETITOR = 3'd1,
    REG_COEF_BEST       = 3'd2,
    REG_COEF_MAGNITUDE  = 3'd3,
    REG_BETA_COUNT      = 3'd4,
    REG_BETA_FIXED      = 3'd5,
    REG_BETA_ENABLE     = 3'd6,
    REG_COMP_LIMIT      = 3'd7
  } reg_index_t;

  // Q2.6 scale with floor: v*c >>> 6, v signed 20 bits, result 20 bits
  function automatic logic signed [19:0] scale_q26(input logic signed [19:0] v,
                                                   input logic [7:0] c);
    logic signed [28:0] p;
    p = v * $signed({1'b0, c});
    return p[25:6];
  endfunction
endpackage
`default_nettype wire

/* rtl/core/chase_pyndiah_soft_output.sv */
// Chase-Pyndiah soft-output stage, one code row per start item; depends on cpso_pkg.
// Flow: loads fill the stores; a start runs the metric pass, the sort and the beta sum, then per
// position a competitor scan and an output step that holds its result while out_stall is high.
// Throughput: loads one per cycle; a start blocks input until its last output is taken.
// Reset: synchronous rst clears control and sets config to its defaults; sample stores stay undefined.
`default_nettype none
module chase_pyndiah_soft_output #(
  parameter int CODE_LENGTH    = 64,
  parameter int TEST_VECTORS   = 16,
  parameter int LEAST_RELIABLE = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               valid,
  output logic                    stall,
  input  wire logic [1:0]         func,
  input  wire logic [5:0]         position,
  input  wire logic [3:0]         vector_index,
  input  wire logic signed [7:0]  metric_sample,
  input  wire logic signed [7:0]  channel_sample,
  input  wire logic               hard_bit,
  input  wire logic [63:0]        vector_bits,
  input  wire logic               vector_invalid,
  input  wire logic [7:0]         lrp_metric,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      soft_out,
  output logic [5:0]              out_position,
  output logic                    last,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import cpso_pkg::*;

  localparam int PW = $clog2(CODE_LENGTH);
  localparam int VW = $clog2(TEST_VECTORS);
  localparam int LW = (LEAST_RELIABLE > 1) ? $clog2(LEAST_RELIABLE) : 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_METRIC, ST_SORT, ST_BETA, ST_SCAN, ST_OUT
  } state_t;

  // configuration
  logic [7:0] coef_channel, coef_competitor, coef_best_metric, coef_magnitude;
  logic [3:0] beta_sum_count;
  logic signed [15:0] beta_fixed;
  logic beta_fixed_enable;
  logic [4:0] competitor_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_channel <= 8'd64; coef_competitor <= 8'd64;
      coef_best_metric <= 8'd64; coef_magnitude <= 8'd64;
      beta_sum_count <= '0; beta_fixed <= '0; beta_fixed_enable <= 1'b0;
      competitor_limit <= 5'd16;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_COEF_CHANNEL:    coef_channel <= cfg_data[7:0];
        REG_COEF_COMPETITOR: coef_competitor <= cfg_data[7:0];
        REG_COEF_BEST:       coef_best_metric <= cfg_data[7:0];
        REG_COEF_MAGNITUDE:  coef_magnitude <= cfg_data[7:0];
        REG_BETA_COUNT:      beta_sum_count <= cfg_data[3:0];
        REG_BETA_FIXED:      beta_fixed <= cfg_data;
        REG_BETA_ENABLE:     beta_fixed_enable <= cfg_data[0];
        REG_COMP_LIMIT:      competitor_limit <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // stores
  logic signed [7:0] msamp [CODE_LENGTH];
  logic signed [7:0] csamp [CODE_LENGTH];
  logic [CODE_LENGTH-1:0] hbits;
  logic [CODE_LENGTH-1:0] rows [TEST_VECTORS];
  logic [TEST_VECTORS-1:0] inval;
  logic [7:0] lrp [LEAST_RELIABLE];
  logic [15:0] vmetric [TEST_VECTORS];
  logic [VW-1:0] order [TEST_VECTORS];

  state_t state;
  logic [PW-1:0] pos;
  logic [VW-1:0] vi;
  logic [VW-1:0] vj;
  logic signed [7:0] msq, csq;
  logic [4:0] good;
  logic signed [19:0] beta, best;
  logic [LW:0] lcnt;
  logic [VW:0] comp;
  logic found;

  wire accept = valid && !stall;
  assign stall = (state != ST_IDLE);

  // loads
  always_ff @(posedge clk) begin
    if (accept && func_t'(func) == FUNC_SAMPLE && {2'b0, position} < 8'(CODE_LENGTH)) begin
      msamp[position[PW-1:0]] <= metric_sample;
      csamp[position[PW-1:0]] <= channel_sample;
      hbits[position[PW-1:0]] <= hard_bit;
    end
    if (accept && func_t'(func) == FUNC_VECTOR && {1'b0, vector_index} < 5'(TEST_VECTORS)) begin
      rows[vector_index[VW-1:0]] <= vector_bits[CODE_LENGTH-1:0];
      inval[vector_index[VW-1:0]] <= vector_invalid;
    end
    if (accept && func_t'(func) == FUNC_LRP && {2'b0, position} < 8'(LEAST_RELIABLE))
      lrp[position[LW-1:0]] <= lrp_metric;
  end

  // shared units
  logic [7:0] mag_m;
  assign mag_m = msq[7] ? 8'(-msq) : 8'(msq);
  logic [CODE_LENGTH-1:0] dw;
  assign dw = rows[order[0]];
  logic signed [19:0] y, yabs;
  assign y = 20'(csq);
  assign yabs = y[19] ? -y : y;
  logic [LW:0] nsum;
  assign nsum = (beta_sum_count == 4'd0 || 32'(beta_sum_count) > LEAST_RELIABLE)
                ? (LW+1)'(LEAST_RELIABLE) : (LW+1)'(beta_sum_count);
  logic [4:0] gcap;
  assign gcap = (competitor_limit < good) ? competitor_limit : good;
  logic signed [19:0] rel, rel2, relc;
  always_comb begin
    if (found)
      rel = scale_q26(20'(vmetric[order[comp[VW-1:0]]]) - best, coef_competitor);
    else if (beta_fixed_enable)
      rel = beta;
    else begin
      rel = beta + scale_q26(yabs, coef_magnitude);
      if (rel < 0) rel = '0;
    end
    rel2 = (dw[pos] ? -rel : rel) - scale_q26(y, coef_channel);
    if (rel2 > 20'sd32767) relc = 20'sd32767;
    else if (rel2 < -20'sd32768) relc = -20'sd32768;
    else relc = rel2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; out_valid <= 1'b0;
      for (int i = 0; i < TEST_VECTORS; i++) begin
        order[i] <= VW'(i); vmetric[i] <= '0;
      end
      good <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && func_t'(func) == FUNC_START) begin
            state <= ST_METRIC; vi <= '0; pos <= '0; good <= '0;
            msq <= msamp[0];
            for (int i = 0; i < TEST_VECTORS; i++) vmetric[i] <= '0;
          end
        end
        // one candidate of one position per cycle; fetch the next sample on the last one
        ST_METRIC: begin
          logic [15:0] a;
          a = vmetric[vi] + ((rows[vi][pos] != hbits[pos]) ? 16'(mag_m) : 16'd0);
          if (pos == PW'(CODE_LENGTH-1)) begin
            vmetric[vi] <= inval[vi] ? 16'(MetricInvalid) : a;
            if (!inval[vi]) good <= good + 5'd1;
          end else vmetric[vi] <= a;
          order[vi] <= vi;
          if (vi == VW'(TEST_VECTORS-1)) begin
            vi <= '0;
            if (pos == PW'(CODE_LENGTH-1)) begin
              state <= ST_SORT; vj <= '0;
            end else begin
              pos <= pos + 1'b1; msq <= msamp[pos + 1'b1];
            end
          end else vi <= vi + 1'b1;
        end
        // bubble sort: one compare-swap per cycle, stable
        ST_SORT: begin
          if (vmetric[order[vj]] > vmetric[order[vj+1'b1]]) begin
            order[vj] <= order[vj+1'b1]; order[vj+1'b1] <= order[vj];
          end
          if (vj == VW'(TEST_VECTORS-2)) begin
            vj <= '0;
            if (vi == VW'(TEST_VECTORS-1)) begin
              state <= ST_BETA; lcnt <= '0; beta <= '0;
              best <= '0;
            end else vi <= vi + 1'b1;
          end else vj <= vj + 1'b1;
        end
        // accumulate LRP sum then subtract scaled best, or load beta_fixed when enabled
        ST_BETA: begin
          if (lcnt < nsum) begin
            beta <= beta + 20'(lrp[lcnt[LW-1:0]]);
            lcnt <= lcnt + 1'b1;
          end else begin
            if (beta_fixed_enable) beta <= 20'(beta_fixed);
            else beta <= beta - scale_q26(20'(vmetric[order[0]]), coef_best_metric);
            best <= 20'(vmetric[order[0]]);
            good <= gcap;
            csq <= csamp[0];
            state <= ST_SCAN; pos <= '0; comp <= (VW+1)'(1); found <= 1'b0;
          end
        end
        // scan competitors for the first differing bit
        ST_SCAN: begin
          if (32'(comp) >= 32'(good)) begin
            found <= 1'b0; state <= ST_OUT;
          end else if (rows[order[comp[VW-1:0]]][pos] != dw[pos]) begin
            found <= 1'b1; state <= ST_OUT;
          end else comp <= comp + 1'b1;
        end
        ST_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1; soft_out <= relc[15:0];
            out_position <= 6'(pos); last <= (pos == PW'(CODE_LENGTH-1));
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            if (pos == PW'(CODE_LENGTH-1)) state <= ST_IDLE;
            else begin
              pos <= pos + 1'b1; comp <= (VW+1)'(1); state <= ST_SCAN;
              csq <= csamp[pos + 1'b1];
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_out_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !out_valid) else $error("output while idle");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("output dropped");
  a_good: assert property (@(posedge clk) disable iff (rst)
    32'(good) <= TEST_VECTORS) else $error("good count overflow");
`endif
endmodule
`default_nettype wire
